// ===== hw/rtl/isu_pkg.sv =====
// Package with the shared constants, types and helpers of the Ising spin update unit.
`timescale 1ns / 1ps

package isu_pkg;

  // Lattice geometry. The side is a power of two, so neighbor wrap is plain
  // coordinate arithmetic.
  localparam int SIDE    = 64;
  localparam int COORD_W = $clog2(SIDE);

  // Fixed-point widths: Q1.16 probabilities held in 17 bits.
  localparam int Q_W     = 17;
  localparam int RND_W   = 16;
  localparam int FIELD_W = 4;
  localparam int CNT_W   = 3;

  localparam logic [Q_W-1:0] Q_ONE  = 17'h10000;
  localparam logic [Q_W-1:0] Q_HALF = 17'h08000;

  // Reset image of one lattice row: the left half of the columns is up.
  localparam logic [SIDE-1:0] INIT_ROW = {{(SIDE / 2){1'b0}}, {(SIDE / 2){1'b1}}};

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_METRO_DE4   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_METRO_DE8   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLAUBER_H2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLAUBER_H4  = 3'd4;

  localparam logic MODE_METROPOLIS = 1'b0;
  localparam logic MODE_GLAUBER    = 1'b1;

  typedef struct packed {
    logic           update_mode;
    logic [Q_W-1:0] metro_thresh_de4;
    logic [Q_W-1:0] metro_thresh_de8;
    logic [Q_W-1:0] glauber_up_h2;
    logic [Q_W-1:0] glauber_up_h4;
  } isu_cfg_t;

  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_RD_A  = 7'b0000100,
    ST_RD_B  = 7'b0001000,
    ST_RD_C  = 7'b0010000,
    ST_EVAL  = 7'b0100000,
    ST_WRITE = 7'b1000000
  } isu_state_t;

  // Clamp a loaded probability to one.
  function automatic logic [Q_W-1:0] sat_q(input logic [Q_W-1:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

endpackage

// ===== hw/rtl/isu_if.sv =====
// Channel interfaces of the Ising spin update unit: site requests, results and register writes.
`timescale 1ns / 1ps

interface isu_in_if;
  logic                         valid;
  logic                         ready;
  logic [isu_pkg::COORD_W-1:0]  col_index;
  logic [isu_pkg::COORD_W-1:0]  row_index;
  logic [isu_pkg::RND_W-1:0]    random_value;

  modport source (output valid, col_index, row_index, random_value, input ready);
  modport sink (input valid, col_index, row_index, random_value, output ready);
endinterface

interface isu_out_if;
  logic                               valid;
  logic                               ready;
  logic [isu_pkg::COORD_W-1:0]        site_col;
  logic [isu_pkg::COORD_W-1:0]        site_row;
  logic                               new_spin;
  logic                               flipped;
  logic signed [isu_pkg::FIELD_W-1:0] local_field;

  modport source (output valid, site_col, site_row, new_spin, flipped, local_field,
                  input ready);
  modport sink (input valid, site_col, site_row, new_spin, flipped, local_field,
                output ready);
endinterface

interface isu_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [isu_pkg::CFG_IDX_W-1:0] index;
  logic [isu_pkg::Q_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/isu_lattice_mem.sv =====
// Spin lattice storage: one row of spins per word, one write and one registered read port.
`timescale 1ns / 1ps

module isu_lattice_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [isu_pkg::COORD_W-1:0] wr_addr,
  input  logic [isu_pkg::SIDE-1:0]    wr_data,
  input  logic                        rd_en,
  input  logic [isu_pkg::COORD_W-1:0] rd_addr,
  output logic [isu_pkg::SIDE-1:0]    rd_data
);

  logic [isu_pkg::SIDE-1:0] mem [isu_pkg::SIDE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/isu_decide.sv =====
// Acceptance logic: turns the neighbor count, old spin and random value into the new spin.
`timescale 1ns / 1ps

module isu_decide (
  input  isu_pkg::isu_cfg_t                  cfg,
  input  logic [isu_pkg::CNT_W-1:0]          up_count,
  input  logic                               old_spin,
  input  logic [isu_pkg::RND_W-1:0]          rnd,
  output logic                               new_spin,
  output logic signed [isu_pkg::FIELD_W-1:0] field
);

  logic                   field_neg;
  logic                   field_zero;
  logic                   field_big;
  logic                   aligned;
  logic [isu_pkg::Q_W-1:0] metro_thresh;
  logic [isu_pkg::Q_W-1:0] up_prob_pos;
  logic [isu_pkg::Q_W-1:0] up_prob;
  logic [isu_pkg::Q_W-1:0] rnd_q;
  logic                   flip;

  // The field is 2 * (up neighbors) - 4.
  assign field      = signed'({1'b0, up_count} + {1'b0, up_count} - 4'd4);
  assign field_neg  = (up_count < 3'd2);
  assign field_zero = (up_count == 3'd2);
  assign field_big  = (up_count == 3'd0) || (up_count == 3'd4);
  assign rnd_q      = {1'b0, rnd};

  // The energy rises only when the spin points along its field.
  assign aligned = old_spin ? (up_count > 3'd2) : (up_count < 3'd2);

  always_comb begin
    metro_thresh = field_big ? isu_pkg::sat_q(cfg.metro_thresh_de8)
                             : isu_pkg::sat_q(cfg.metro_thresh_de4);
    flip = !aligned || (rnd_q < metro_thresh);

    if (field_zero) begin
      up_prob_pos = isu_pkg::Q_HALF;
    end else if (field_big) begin
      up_prob_pos = isu_pkg::sat_q(cfg.glauber_up_h4);
    end else begin
      up_prob_pos = isu_pkg::sat_q(cfg.glauber_up_h2);
    end
    up_prob = field_neg ? (isu_pkg::Q_ONE - up_prob_pos) : up_prob_pos;

    if (cfg.update_mode == isu_pkg::MODE_GLAUBER) begin
      new_spin = (rnd_q < up_prob);
    end else begin
      new_spin = flip ? !old_spin : old_spin;
    end
  end

endmodule

// ===== hw/rtl/ising_spin_update_unit.sv =====
// Top level of the Ising spin update unit: sequencer, registers, lattice and result stage.
`timescale 1ns / 1ps
//
// The unit holds a 64 x 64 lattice of spins with periodic boundaries and
// updates one site per transaction on in_ch (column, row, 16-bit random value).
// Each update produces one transaction on out_ch carrying the site, the new
// spin, a flip flag and the neighbor field. cfg_ch writes the mode and the
// Q1.16 thresholds; it is always ready and is meant to be used while idle.
//
// The lattice is stored one row per word behind a single read port. An update
// reads the row above, the row below and the site's own row on that port, one
// per cycle, accumulating up-neighbors as the words arrive, then decides and
// writes the row back. A site is accepted in idle; the update then steps through
// RD_A, RD_B, RD_C and EVAL and loads its result in WRITE; no new site is taken until then.
//
// After reset the unit writes the initial lattice (left half up) one row per
// cycle, all 64 rows, with in_ch.ready low. Results wait in an output register;
// a new site can be taken while it waits, and the write-back stalls only when
// the next result is ready before the previous one has been taken.

module ising_spin_update_unit (
  input  logic         clk,
  input  logic         rst,
  isu_in_if.sink       in_ch,
  isu_out_if.source    out_ch,
  isu_cfg_if.sink      cfg_ch
);

  isu_pkg::isu_state_t state;
  isu_pkg::isu_cfg_t   cfg;

  logic [isu_pkg::COORD_W-1:0] init_cnt;
  logic [isu_pkg::COORD_W-1:0] col;
  logic [isu_pkg::COORD_W-1:0] row;
  logic [isu_pkg::RND_W-1:0]   rnd;
  logic [isu_pkg::CNT_W-1:0]   up_cnt;
  logic [isu_pkg::CNT_W-1:0]   up_cnt_next;
  logic [isu_pkg::SIDE-1:0]    own_row;
  logic [isu_pkg::SIDE-1:0]    own_row_next;
  logic                        old_spin;

  logic [isu_pkg::COORD_W-1:0] col_p;
  logic [isu_pkg::COORD_W-1:0] col_m;
  logic                        out_free;
  logic                        in_take;

  logic                        wr_en;
  logic [isu_pkg::COORD_W-1:0] wr_addr;
  logic [isu_pkg::SIDE-1:0]    wr_data;
  logic                        rd_en;
  logic [isu_pkg::COORD_W-1:0] rd_addr;
  logic [isu_pkg::SIDE-1:0]    rd_data;

  logic                               new_spin;
  logic signed [isu_pkg::FIELD_W-1:0] field;

  assign col_p    = col + 1'b1;
  assign col_m    = col - 1'b1;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = (state == isu_pkg::ST_IDLE);
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.update_mode      <= isu_pkg::MODE_METROPOLIS;
      cfg.metro_thresh_de4 <= '0;
      cfg.metro_thresh_de8 <= '0;
      cfg.glauber_up_h2    <= isu_pkg::Q_HALF;
      cfg.glauber_up_h4    <= isu_pkg::Q_HALF;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        isu_pkg::REG_UPDATE_MODE: cfg.update_mode      <= cfg_ch.data[0];
        isu_pkg::REG_METRO_DE4:   cfg.metro_thresh_de4 <= cfg_ch.data;
        isu_pkg::REG_METRO_DE8:   cfg.metro_thresh_de8 <= cfg_ch.data;
        isu_pkg::REG_GLAUBER_H2:  cfg.glauber_up_h2    <= cfg_ch.data;
        isu_pkg::REG_GLAUBER_H4:  cfg.glauber_up_h4    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Read port schedule: row above, row below, then the site's own row.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = row;
    case (state)
      isu_pkg::ST_RD_A: begin
        rd_en   = 1'b1;
        rd_addr = row - 1'b1;
      end
      isu_pkg::ST_RD_B: begin
        rd_en   = 1'b1;
        rd_addr = row + 1'b1;
      end
      isu_pkg::ST_RD_C: begin
        rd_en   = 1'b1;
        rd_addr = row;
      end
      default: ;
    endcase
  end

  // Each arriving word adds its neighbor bits to the running count.
  always_comb begin
    up_cnt_next = up_cnt;
    case (state)
      isu_pkg::ST_RD_B, isu_pkg::ST_RD_C: begin
        up_cnt_next = up_cnt + {2'b00, rd_data[col]};
      end
      isu_pkg::ST_EVAL: begin
        up_cnt_next = up_cnt + {2'b00, rd_data[col_p]} + {2'b00, rd_data[col_m]};
      end
      default: ;
    endcase
  end

  always_comb begin
    own_row_next      = own_row;
    own_row_next[col] = new_spin;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = row;
    wr_data = own_row_next;
    case (state)
      isu_pkg::ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_cnt;
        wr_data = isu_pkg::INIT_ROW;
      end
      isu_pkg::ST_WRITE: begin
        wr_en = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= isu_pkg::ST_INIT;
      init_cnt <= '0;
    end else begin
      case (state)
        isu_pkg::ST_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == isu_pkg::COORD_W'(isu_pkg::SIDE - 1)) begin
            state <= isu_pkg::ST_IDLE;
          end
        end
        isu_pkg::ST_IDLE: begin
          if (in_take) begin
            state <= isu_pkg::ST_RD_A;
          end
        end
        isu_pkg::ST_RD_A: state <= isu_pkg::ST_RD_B;
        isu_pkg::ST_RD_B: state <= isu_pkg::ST_RD_C;
        isu_pkg::ST_RD_C: state <= isu_pkg::ST_EVAL;
        isu_pkg::ST_EVAL: state <= isu_pkg::ST_WRITE;
        isu_pkg::ST_WRITE: begin
          if (out_free) begin
            state <= isu_pkg::ST_IDLE;
          end
        end
        default: state <= isu_pkg::ST_INIT;
      endcase
    end
  end

  // Working registers of the update in flight.
  always_ff @(posedge clk) begin
    if (in_take) begin
      col    <= in_ch.col_index;
      row    <= in_ch.row_index;
      rnd    <= in_ch.random_value;
      up_cnt <= '0;
    end else begin
      up_cnt <= up_cnt_next;
    end
    if (state == isu_pkg::ST_EVAL) begin
      own_row  <= rd_data;
      old_spin <= rd_data[col];
    end
  end

  isu_lattice_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  isu_decide u_decide (
    .cfg      (cfg),
    .up_count (up_cnt),
    .old_spin (old_spin),
    .rnd      (rnd),
    .new_spin (new_spin),
    .field    (field)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if ((state == isu_pkg::ST_WRITE) && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == isu_pkg::ST_WRITE) && out_free) begin
      out_ch.site_col    <= col;
      out_ch.site_row    <= row;
      out_ch.new_spin    <= new_spin;
      out_ch.flipped     <= new_spin ^ old_spin;
      out_ch.local_field <= field;
    end
  end

endmodule

// ===== hw/rtl/isu_checker.sv =====
// Port-level checker for the Ising spin update unit, bound to the top level.
`timescale 1ns / 1ps

module isu_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [isu_pkg::COORD_W-1:0]        site_col,
  input logic [isu_pkg::COORD_W-1:0]        site_row,
  input logic                               new_spin,
  input logic                               flipped,
  input logic signed [isu_pkg::FIELD_W-1:0] local_field
);

  // A stalled result must hold its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(site_col) && $stable(site_row)
      && $stable(new_spin) && $stable(flipped) && $stable(local_field))
    else $error("result changed while stalled");

  // The unit works on one site at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("site accepted while an update was in flight");

  // A field is a sum of four unit spins: even and within plus or minus four.
  a_field_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !local_field[0] && (local_field <= 4'sd4) && (local_field >= -4'sd4))
    else $error("illegal local field");

  // The lattice image is written after reset before any site is taken.
  a_init_pass: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("unit ready right after reset");

endmodule

bind ising_spin_update_unit isu_checker u_isu_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .site_col    (out_ch.site_col),
  .site_row    (out_ch.site_row),
  .new_spin    (out_ch.new_spin),
  .flipped     (out_ch.flipped),
  .local_field (out_ch.local_field)
);
